FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// prop must never hold at a clock edge out of reset
`define ASSERT_NEVER(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(prop)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/ldpc_cps_pkg.sv
// ----------------------------------------------------------------------------
// ldpc_cps_pkg
// Types, constants and lifting tables for LDPC code parameter selection.
// ----------------------------------------------------------------------------
package ldpc_cps_pkg;

   localparam int unsigned MAX_LIFT   = 384;
   localparam int unsigned LIFT_COUNT = 51;
   localparam int unsigned LIFT_IDX_W = $clog2(LIFT_COUNT);

   localparam logic [16:0] A_THR_1       = 17'd292;
   localparam logic [16:0] A_THR_2       = 17'd3824;
   localparam logic [16:0] BG2_A_MAX     = 17'd3840;
   localparam logic [16:0] BG1_A_MAX     = 17'd8448;
   localparam logic [15:0] RATE_THR_LOW  = 16'd8192;   // 0.25 in Q1.15
   localparam logic [15:0] RATE_THR_HIGH = 16'd21954;  // 0.67 in Q1.15

   localparam logic [16:0] KB_THR_10 = 17'd640;
   localparam logic [16:0] KB_THR_9  = 17'd560;
   localparam logic [16:0] KB_THR_8  = 17'd192;

   localparam logic [4:0] KB_BG1    = 5'd22;
   localparam logic [4:0] KB_BG2_10 = 5'd10;
   localparam logic [4:0] KB_BG2_9  = 5'd9;
   localparam logic [4:0] KB_BG2_8  = 5'd8;
   localparam logic [4:0] KB_BG2_6  = 5'd6;

   localparam logic [1:0] ERR_OK      = 2'd0;
   localparam logic [1:0] ERR_BG2_SEG = 2'd1;
   localparam logic [1:0] ERR_BG1_SEG = 2'd2;

   localparam logic [8:0] LIFT_DEFAULT = 9'(MAX_LIFT);
   localparam logic [2:0] SET_DEFAULT  = 3'd1;

   typedef struct packed {
      logic [15:0] code_length;
      logic [15:0] code_rate;
   } req_type;

   typedef struct packed {
      logic [1:0]  error_code;
      logic        base_graph;
      logic [4:0]  info_columns;
      logic [8:0]  lift_size;
      logic [2:0]  set_index;
      logic [15:0] info_length;
      logic [13:0] message_length;
      logic [14:0] codeword_bits;
      logic [13:0] filler_count;
   } rsp_type;

   // lifting sizes sorted ascending
   function automatic logic [8:0] lift_value(input logic [LIFT_IDX_W-1:0] idx);
      logic [8:0] z;
      case (idx)
         6'd0:  z = 9'd2;    6'd1:  z = 9'd3;    6'd2:  z = 9'd4;
         6'd3:  z = 9'd5;    6'd4:  z = 9'd6;    6'd5:  z = 9'd7;
         6'd6:  z = 9'd8;    6'd7:  z = 9'd9;    6'd8:  z = 9'd10;
         6'd9:  z = 9'd11;   6'd10: z = 9'd12;   6'd11: z = 9'd13;
         6'd12: z = 9'd14;   6'd13: z = 9'd15;   6'd14: z = 9'd16;
         6'd15: z = 9'd18;   6'd16: z = 9'd20;   6'd17: z = 9'd22;
         6'd18: z = 9'd24;   6'd19: z = 9'd26;   6'd20: z = 9'd28;
         6'd21: z = 9'd30;   6'd22: z = 9'd32;   6'd23: z = 9'd36;
         6'd24: z = 9'd40;   6'd25: z = 9'd44;   6'd26: z = 9'd48;
         6'd27: z = 9'd52;   6'd28: z = 9'd56;   6'd29: z = 9'd60;
         6'd30: z = 9'd64;   6'd31: z = 9'd72;   6'd32: z = 9'd80;
         6'd33: z = 9'd88;   6'd34: z = 9'd96;   6'd35: z = 9'd104;
         6'd36: z = 9'd112;  6'd37: z = 9'd120;  6'd38: z = 9'd128;
         6'd39: z = 9'd144;  6'd40: z = 9'd160;  6'd41: z = 9'd176;
         6'd42: z = 9'd192;  6'd43: z = 9'd208;  6'd44: z = 9'd224;
         6'd45: z = 9'd240;  6'd46: z = 9'd256;  6'd47: z = 9'd288;
         6'd48: z = 9'd320;  6'd49: z = 9'd352;  6'd50: z = 9'd384;
         default: z = LIFT_DEFAULT;
      endcase
      return z;
   endfunction

   // set index of each sorted lifting size
   function automatic logic [2:0] lift_set(input logic [LIFT_IDX_W-1:0] idx);
      logic [2:0] s;
      case (idx)
         6'd0:  s = 3'd0;  6'd1:  s = 3'd1;  6'd2:  s = 3'd0;  6'd3:  s = 3'd2;
         6'd4:  s = 3'd1;  6'd5:  s = 3'd3;  6'd6:  s = 3'd0;  6'd7:  s = 3'd4;
         6'd8:  s = 3'd2;  6'd9:  s = 3'd5;  6'd10: s = 3'd1;  6'd11: s = 3'd6;
         6'd12: s = 3'd3;  6'd13: s = 3'd7;  6'd14: s = 3'd0;  6'd15: s = 3'd4;
         6'd16: s = 3'd2;  6'd17: s = 3'd5;  6'd18: s = 3'd1;  6'd19: s = 3'd6;
         6'd20: s = 3'd3;  6'd21: s = 3'd7;  6'd22: s = 3'd0;  6'd23: s = 3'd4;
         6'd24: s = 3'd2;  6'd25: s = 3'd5;  6'd26: s = 3'd1;  6'd27: s = 3'd6;
         6'd28: s = 3'd3;  6'd29: s = 3'd7;  6'd30: s = 3'd0;  6'd31: s = 3'd4;
         6'd32: s = 3'd2;  6'd33: s = 3'd5;  6'd34: s = 3'd1;  6'd35: s = 3'd6;
         6'd36: s = 3'd3;  6'd37: s = 3'd7;  6'd38: s = 3'd0;  6'd39: s = 3'd4;
         6'd40: s = 3'd2;  6'd41: s = 3'd5;  6'd42: s = 3'd1;  6'd43: s = 3'd6;
         6'd44: s = 3'd3;  6'd45: s = 3'd7;  6'd46: s = 3'd0;  6'd47: s = 3'd4;
         6'd48: s = 3'd2;  6'd49: s = 3'd5;  6'd50: s = 3'd1;
         default: s = SET_DEFAULT;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/core/ldpc_code_parameter_select.sv
// ----------------------------------------------------------------------------
// ldpc_code_parameter_select
// Picks the LDPC base graph, Kb, lifting size and derived code sizes.
// ----------------------------------------------------------------------------
// A request word (code length M, rate in Q1.15) is taken at every clock edge
// where start is high; busy is always low, so a new word may follow in every
// cycle. Each result word appears on rsp_data with rsp_strobe high for one
// cycle, in request order, after passing through the five-stage pipeline
// (multiply, graph/Kb decision, lift compare bank, lift select, size
// products). The receiver cannot stall, so the pipeline never holds. On a
// segmentation error only error_code is nonzero.
`include "assert_macros.svh"

module ldpc_code_parameter_select (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ldpc_cps_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output ldpc_cps_pkg::rsp_type rsp_data
);

   localparam int unsigned NL = ldpc_cps_pkg::LIFT_COUNT;

   logic accept;

   // stage 1: product M*rate
   logic        v1_ff;
   logic [31:0] prod1_ff;
   logic [15:0] rate1_ff;

   // stage 2: A, graph, Kb, error
   logic        v2_ff;
   logic [16:0] a2_ff, a2_in;
   logic        bg2_2_ff, bg2_2_in;
   logic [1:0]  err2_ff, err2_in;
   logic [4:0]  kb2_ff, kb2_in;

   // stage 3: compare bank
   logic          v3_ff;
   logic [NL-1:0] hit3_ff, hit3_in;
   logic [16:0]   a3_ff;
   logic          bg2_3_ff;
   logic [1:0]    err3_ff;
   logic [4:0]    kb3_ff;

   // stage 4: selected lift
   logic        v4_ff;
   logic [8:0]  zc4_ff, zc4_in;
   logic [2:0]  set4_ff, set4_in;
   logic [16:0] a4_ff;
   logic        bg2_4_ff;
   logic [1:0]  err4_ff;
   logic [4:0]  kb4_ff;

   // stage 5: output register
   logic                  v5_ff;
   ldpc_cps_pkg::rsp_type rsp_ff, rsp_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= 32'(req_data.code_length) * 32'(req_data.code_rate);
      rate1_ff <= req_data.code_rate;
   end

   always_comb begin
      a2_in    = prod1_ff[31:15];
      bg2_2_in = (a2_in <= ldpc_cps_pkg::A_THR_1) ||
                 ((a2_in <= ldpc_cps_pkg::A_THR_2) &&
                  (rate1_ff <= ldpc_cps_pkg::RATE_THR_HIGH)) ||
                 (rate1_ff <= ldpc_cps_pkg::RATE_THR_LOW);
      if (bg2_2_in && (a2_in > ldpc_cps_pkg::BG2_A_MAX)) begin
         err2_in = ldpc_cps_pkg::ERR_BG2_SEG;
      end else if (!bg2_2_in && (a2_in > ldpc_cps_pkg::BG1_A_MAX)) begin
         err2_in = ldpc_cps_pkg::ERR_BG1_SEG;
      end else begin
         err2_in = ldpc_cps_pkg::ERR_OK;
      end
      if (!bg2_2_in) begin
         kb2_in = ldpc_cps_pkg::KB_BG1;
      end else if (a2_in > ldpc_cps_pkg::KB_THR_10) begin
         kb2_in = ldpc_cps_pkg::KB_BG2_10;
      end else if (a2_in > ldpc_cps_pkg::KB_THR_9) begin
         kb2_in = ldpc_cps_pkg::KB_BG2_9;
      end else if (a2_in > ldpc_cps_pkg::KB_THR_8) begin
         kb2_in = ldpc_cps_pkg::KB_BG2_8;
      end else begin
         kb2_in = ldpc_cps_pkg::KB_BG2_6;
      end
   end

   always_ff @(posedge clock) begin
      a2_ff    <= a2_in;
      bg2_2_ff <= bg2_2_in;
      err2_ff  <= err2_in;
      kb2_ff   <= kb2_in;
   end

   // table is sorted, so the hit vector is a thermometer from the top
   always_comb begin
      for (int i = 0; i < NL; i++) begin
         hit3_in[i] = (17'(kb2_ff) *
                       17'(ldpc_cps_pkg::lift_value(ldpc_cps_pkg::LIFT_IDX_W'(i))))
                      >= a2_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit3_ff  <= hit3_in;
      a3_ff    <= a2_ff;
      bg2_3_ff <= bg2_2_ff;
      err3_ff  <= err2_ff;
      kb3_ff   <= kb2_ff;
   end

   // first hit: its own bit set, the one below clear
   always_comb begin
      logic first;
      zc4_in  = '0;
      set4_in = '0;
      for (int i = 0; i < NL; i++) begin
         if (i == 0) begin
            first = hit3_ff[i];
         end else begin
            first = hit3_ff[i] & ~hit3_ff[i-1];
         end
         if (first) begin
            zc4_in  = zc4_in |
                      ldpc_cps_pkg::lift_value(ldpc_cps_pkg::LIFT_IDX_W'(i));
            set4_in = set4_in |
                      ldpc_cps_pkg::lift_set(ldpc_cps_pkg::LIFT_IDX_W'(i));
         end
      end
      if (hit3_ff == '0) begin
         zc4_in  = ldpc_cps_pkg::LIFT_DEFAULT;
         set4_in = ldpc_cps_pkg::SET_DEFAULT;
      end
   end

   always_ff @(posedge clock) begin
      zc4_ff   <= zc4_in;
      set4_ff  <= set4_in;
      a4_ff    <= a3_ff;
      bg2_4_ff <= bg2_3_ff;
      err4_ff  <= err3_ff;
      kb4_ff   <= kb3_ff;
   end

   always_comb begin
      logic [13:0] k;
      logic [14:0] n;
      k = bg2_4_ff ? 14'(zc4_ff) * 14'd10 : 14'(zc4_ff) * 14'd22;
      n = bg2_4_ff ? 15'(zc4_ff) * 15'd50 : 15'(zc4_ff) * 15'd66;
      rsp_in = '0;
      rsp_in.error_code = err4_ff;
      if (err4_ff == ldpc_cps_pkg::ERR_OK) begin
         rsp_in.base_graph     = bg2_4_ff;
         rsp_in.info_columns   = kb4_ff;
         rsp_in.lift_size      = zc4_ff;
         rsp_in.set_index      = set4_ff;
         rsp_in.info_length    = a4_ff[15:0];
         rsp_in.message_length = k;
         rsp_in.codeword_bits  = n;
         rsp_in.filler_count   = k - a4_ff[13:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = v5_ff;
   assign rsp_data   = rsp_ff;

   `ASSERT_ALWAYS(a_latency, rsp_strobe |-> $past(accept, 5))
   `ASSERT_NEVER(a_hit_thermo, v3_ff && (({hit3_ff[NL-2:0], 1'b0} & ~hit3_ff) != '0))
   `ASSERT_ALWAYS(a_err_zero,
      (rsp_strobe && rsp_data.error_code != ldpc_cps_pkg::ERR_OK) |->
      (rsp_data.lift_size == '0 && rsp_data.base_graph == 1'b0 &&
       rsp_data.info_length == '0))
   `ASSERT_ALWAYS(a_k_covers_a,
      (rsp_strobe && rsp_data.error_code == ldpc_cps_pkg::ERR_OK) |->
      (rsp_data.lift_size != '0 &&
       16'(rsp_data.message_length) >= rsp_data.info_length))

endmodule
